// File: hdl/rcs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcs_pkg: shared types and constants for the raycast column renderer
// Word formats, divider cell record and the fisheye factor table.
// ---------------------------------------------------------------------------
package rcs_pkg;

	// screen geometry
	localparam int unsigned COLUMNS = 128;
	localparam int unsigned ROWS    = 64;

	// fixed field widths
	localparam int unsigned COL_W    = 7;
	localparam int unsigned DEPTH_W  = 16;
	localparam int unsigned PIX_W    = 64;
	localparam int unsigned HGT_W    = 7;
	localparam int unsigned FACTOR_W = 16;
	localparam int unsigned PROD_W   = DEPTH_W + FACTOR_W;
	localparam int unsigned FRAC_W   = 15;
	localparam int unsigned COL_ENTRIES = 2 ** COL_W;

	// row index width and divider geometry
	localparam int unsigned ROW_W = (ROWS > 2) ? $clog2(ROWS) : 1;
	localparam int unsigned NUM   = ROWS * 100;
	localparam int unsigned NUM_W = $clog2(NUM + 1);
	localparam int unsigned REM_W = DEPTH_W;

	// lower bound applied to depth and corrected depth, in hundredths
	localparam logic [DEPTH_W-1:0] DEPTH_MIN = DEPTH_W'(10);

	typedef struct packed {
		logic [COL_W-1:0]   column;
		logic [DEPTH_W-1:0] depth;
	} item_t;

	typedef struct packed {
		logic [COL_W-1:0] column_index;
		logic [PIX_W-1:0] column_pixels;
		logic [HGT_W-1:0] line_height;
	} result_t;

	// word handed from one divider cell to the next
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [REM_W-1:0] divisor;
		logic [REM_W-1:0] rem;
		logic [NUM_W-1:0] quo;
	} div_t;

	typedef logic [FACTOR_W-1:0] factor_rom_t [COL_ENTRIES];

	// floor(32768 * C / sqrt(C^2 + d^2)), d = |2x - C|, found by binary search
	function automatic logic [FACTOR_W-1:0] fisheye_factor(int unsigned x);
		longint unsigned c;
		longint unsigned two_x;
		longint unsigned d;
		longint unsigned den;
		longint unsigned target;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mid;
		c = longint'(COLUMNS);
		two_x = 2 * longint'(x);
		d = (two_x >= c) ? (two_x - c) : (c - two_x);
		den = c * c + d * d;
		target = (64'd1 << 30) * c * c;
		lo = 0;
		hi = 32768;
		for (int i = 0; i < 17; i++) begin
			if (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (mid * mid * den <= target)
					lo = mid;
				else
					hi = mid - 1;
			end
		end
		return lo[FACTOR_W-1:0];
	endfunction

	function automatic factor_rom_t build_factor_rom();
		factor_rom_t rom;
		for (int unsigned x = 0; x < COL_ENTRIES; x++)
			rom[x] = fisheye_factor(x);
		return rom;
	endfunction

endpackage

// File: hdl/rcs_div_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rcs_div_cell: one restoring-division cell
// Shifts in one dividend bit, trial-subtracts the divisor, appends one
// quotient bit and hands the word to the next cell.
// ---------------------------------------------------------------------------
module rcs_div_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  rcs_pkg::div_t in_word,
	input  logic         num_bit,
	output logic         valid_q,
	output rcs_pkg::div_t word_q
);
	import rcs_pkg::*;

	logic [REM_W:0] trial;
	logic           fits;
	div_t           word_d;

	// trial subtract of the shifted remainder
	always_comb begin
		trial  = {in_word.rem, num_bit};
		fits   = (trial >= {1'b0, in_word.divisor});
		word_d = in_word;
		word_d.quo = {in_word.quo[NUM_W-2:0], fits};
		if (fits)
			word_d.rem = REM_W'(trial - {1'b0, in_word.divisor});
		else
			word_d.rem = trial[REM_W-1:0];
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= in_valid;
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv && in_valid)
			word_q <= word_d;
	end

endmodule

// File: hdl/raycast_column_span_render.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// raycast_column_span_render: wall column mask renderer
// Fisheye-corrects a column depth, divides it into the wall height through a
// chain of division cells and builds the one-bit-per-row column mask.
// ---------------------------------------------------------------------------
// Pipeline: input/ROM stage, multiply stage, one divider cell per quotient bit,
//   then the mask output register.
// Throughput, when not stalled: one word per cycle, one new divide per cycle.
// Stages with no word in them fill while the output is stalled.
// Reset clears all occupancy flags and test_pattern; payload is not reset.
module raycast_column_span_render (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic            wr_data,
	input  logic            item_valid,
	output logic            item_stall,
	input  rcs_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_stall,
	output rcs_pkg::result_t result
);
	import rcs_pkg::*;

	localparam factor_rom_t FACTOR_ROM = build_factor_rom();
	localparam logic [NUM_W-1:0] NUM_VEC = NUM_W'(NUM);

	logic test_pattern_q;

	logic                v_s1;
	logic [COL_W-1:0]    column_s1;
	logic [DEPTH_W-1:0]  depth_s1;
	logic [FACTOR_W-1:0] factor_s1;

	logic                v_s2;
	logic [COL_W-1:0]    column_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic                adv_s1;
	logic                adv_s2;
	logic                adv_out;
	logic [NUM_W-1:0]    adv_cell;
	logic [NUM_W-1:0]    cell_v;
	div_t                cell_w [NUM_W];
	div_t                div_in;
	logic [PROD_W-FRAC_W-1:0] corr_raw;

	logic    res_v_q;
	result_t res_q;
	result_t res_d;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			test_pattern_q <= 1'b0;
		else if (wr_en)
			test_pattern_q <= wr_data;
	end

	// advance chain: a stage moves when its successor is empty or moving
	assign adv_out = !res_v_q || !result_stall;
	assign adv_s2  = !v_s2 || adv_cell[0];
	assign adv_s1  = !v_s1 || adv_s2;
	assign item_stall = !adv_s1;

	// stage 1: clamp depth, look up fisheye factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv_s1)
			v_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			column_s1 <= item.column;
			depth_s1  <= (item.depth < DEPTH_MIN) ? DEPTH_MIN : item.depth;
			factor_s1 <= FACTOR_ROM[item.column];
		end
	end

	// stage 2: depth times factor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			column_s2 <= column_s1;
			prod_s2   <= PROD_W'(depth_s1) * PROD_W'(factor_s1);
		end
	end

	// corrected depth becomes the divisor of the first cell
	always_comb begin
		corr_raw = prod_s2[PROD_W-1:FRAC_W];
		div_in.column  = column_s2;
		div_in.divisor = (corr_raw < (PROD_W-FRAC_W)'(DEPTH_MIN)) ?
			DEPTH_MIN : corr_raw[REM_W-1:0];
		div_in.rem = '0;
		div_in.quo = '0;
	end

	// division cell chain, most significant quotient bit first
	for (genvar i = 0; i < NUM_W; i++) begin : g_cell
		if (i == NUM_W - 1) begin : g_last
			assign adv_cell[i] = !cell_v[i] || adv_out;
		end else begin : g_mid
			assign adv_cell[i] = !cell_v[i] || adv_cell[i+1];
		end

		if (i == 0) begin : g_head
			rcs_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv_cell[i]),
				.in_valid (v_s2),
				.in_word  (div_in),
				.num_bit  (NUM_VEC[NUM_W-1-i]),
				.valid_q  (cell_v[i]),
				.word_q   (cell_w[i])
			);
		end else begin : g_tail
			rcs_div_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv_cell[i]),
				.in_valid (cell_v[i-1]),
				.in_word  (cell_w[i-1]),
				.num_bit  (NUM_VEC[NUM_W-1-i]),
				.valid_q  (cell_v[i]),
				.word_q   (cell_w[i])
			);
		end
	end

	// height clamp, span limits and row mask
	always_comb begin
		logic [NUM_W-1:0]  quo;
		logic [HGT_W-1:0]  height;
		logic [HGT_W-1:0]  half;
		logic [ROW_W:0]    span_start;
		logic [ROW_W:0]    span_end;
		logic [ROW_W:0]    row;
		logic [2:0]        diag;
		quo = cell_w[NUM_W-1].quo;
		if (quo > NUM_W'(ROWS))
			height = HGT_W'(ROWS);
		else if (quo == '0)
			height = HGT_W'(1);
		else
			height = quo[HGT_W-1:0];
		half = height >> 1;
		span_start = (ROW_W+1)'(ROWS / 2) - (ROW_W+1)'(half);
		span_end   = (ROW_W+1)'(ROWS / 2) + (ROW_W+1)'(half);
		if (span_end > (ROW_W+1)'(ROWS - 1))
			span_end = (ROW_W+1)'(ROWS - 1);

		res_d = '0;
		res_d.column_index = cell_w[NUM_W-1].column;
		res_d.line_height  = test_pattern_q ? HGT_W'(ROWS) : height;
		for (int y = 0; y < ROWS; y++) begin
			row  = (ROW_W+1)'(y);
			diag = cell_w[NUM_W-1].column[2:0] + 3'(row);
			if (test_pattern_q)
				res_d.column_pixels[y] = !diag[2];
			else if (row < span_start)
				res_d.column_pixels[y] = 1'b0;
			else if (row <= span_end)
				res_d.column_pixels[y] = 1'b1;
			else
				res_d.column_pixels[y] = !diag[1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_v_q <= 1'b0;
		else if (adv_out)
			res_v_q <= cell_v[NUM_W-1];
	end

	always_ff @(posedge clk) begin
		if (adv_out && cell_v[NUM_W-1])
			res_q <= res_d;
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

	// an accepted word always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> v_s1)
		else $error("accepted word missing from stage 1");

	// divider output remainder is below its divisor
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[NUM_W-1] |-> (cell_w[NUM_W-1].rem < cell_w[NUM_W-1].divisor))
		else $error("division cell chain left remainder >= divisor");

	// wall height stays within the screen
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.line_height >= HGT_W'(1)) &&
			(result.line_height <= HGT_W'(ROWS)))
		else $error("line_height out of range");

	// outside test-pattern mode the middle row always lies on the wall
	a_mid_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !test_pattern_q) |-> result.column_pixels[ROWS/2])
		else $error("middle row not lit");

	// a stalled stage 2 holds the stage 1 word in place
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv_s2) |=> (v_s1 && $stable(column_s1) && $stable(depth_s1)))
		else $error("stage 1 word lost during stall");

endmodule
